// ===== hdl/hpt_pkg.sv =====
`default_nettype none

package hpt_pkg;

    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    typedef enum logic [2:0] {
        REG_TARGET    = 3'd0,
        REG_GAIN_P    = 3'd1,
        REG_GAIN_I    = 3'd2,
        REG_GAIN_D    = 3'd3,
        REG_THRESHOLD = 3'd4
    } reg_idx_t;

    localparam logic signed [16:0] TARGET_RST    = 17'sd0;
    localparam logic [27:0]        GAIN_P_RST    = 28'd1153434;
    localparam logic [27:0]        GAIN_I_RST    = 28'd105;
    localparam logic [27:0]        GAIN_D_RST    = 28'd16305357;
    localparam logic [15:0]        THRESHOLD_RST = 16'd13;

    localparam logic signed [17:0] WRAP_HALF    = 18'sd46080;
    localparam logic signed [17:0] WRAP_FULL    = 18'sd92160;
    localparam logic [5:0]         SETTLE_STEPS = 6'd50;
    localparam logic [39:0]        SUM_MAX      = {1'b0, {39{1'b1}}};
    localparam logic [39:0]        SUM_MIN      = {1'b1, {39{1'b0}}};
    localparam logic [67:0]        TERM_LIMIT   = 68'd1 << 52;
    localparam logic [55:0]        DRIVE_LIMIT  = 56'd26843545600;
    // 1560/100 = 78/5: scale by 78, drop 28 fraction bits, then divide by 5
    localparam logic [27:0]        SPEED_MUL    = 28'd78;
    localparam logic [27:0]        RECIP_FIVE   = 28'd52429;

    typedef struct packed {
        logic signed [16:0] target;
        logic [27:0]        gain_p;
        logic [27:0]        gain_i;
        logic [27:0]        gain_d;
        logic [15:0]        threshold;
    } cfg_t;

    typedef enum logic [2:0] {
        MUL_P  = 3'd0,
        MUL_D  = 3'd1,
        MUL_IL = 3'd2,
        MUL_IH = 3'd3,
        MUL_S  = 3'd4,
        MUL_Q  = 3'd5
    } mul_sel_t;

    typedef enum logic [1:0] {
        ACC_HOLD   = 2'd0,
        ACC_LOAD_P = 2'd1,
        ACC_ADD_D  = 2'd2,
        ACC_ADD_I  = 2'd3
    } acc_op_t;

    typedef struct packed {
        logic     capture;
        logic     wrap;
        logic     update;
        logic     mul_en;
        mul_sel_t mul_sel;
        acc_op_t  acc_op;
        logic     save_lo;
        logic     isat;
        logic     clamp;
        logic     result;
    } cmd_t;

    typedef struct packed {
        logic out_busy;
    } status_t;

endpackage

`default_nettype wire

// ===== hdl/heading_pid_turn_controller_core.sv =====
`default_nettype none

// Heading PID turn controller. Each s_ transfer carries one measured heading
// (1/256 degree); each m_ transfer returns the left and right wheel speeds
// (+-1560) and a one-step stable flag. The error is wrapped into +-180 degrees,
// the integral sum saturates at 40 bits, and the drive is clamped to +-100.
// A heading is accepted only once the result of the last has moved to the
// output register. A single 28x36 multiplier is used six times in sequence
// (P, D, two halves of I, speed scale, divide by five). A finished result
// waits in the output register while the next heading is accepted.
// Registers on the APB port at byte addresses: 0x00 target_heading,
// 0x04 gain_proportional, 0x08 gain_integral, 0x0C gain_derivative
// (gains unsigned Q8.20), 0x10 settle_threshold. Write only while idle.
module heading_pid_turn_controller_core (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic signed [16:0]         s_measured_heading,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic signed [11:0]         m_speed_left,
    output logic signed [11:0]         m_speed_right,
    output logic                       m_stable_pulse,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [hpt_pkg::ADDR_W-1:0] paddr,
    input  logic [hpt_pkg::DATA_W-1:0] pwdata,
    output logic [hpt_pkg::DATA_W-1:0] prdata,
    output logic                       pready
);
    import hpt_pkg::*;

    cfg_t    cfg;
    cmd_t    cmd;
    status_t status;

    hpt_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    hpt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    hpt_dp u_dp (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg                (cfg),
        .cmd                (cmd),
        .status             (status),
        .s_measured_heading (s_measured_heading),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_speed_left       (m_speed_left),
        .m_speed_right      (m_speed_right),
        .m_stable_pulse     (m_stable_pulse)
    );

endmodule

`default_nettype wire

// ===== hdl/hpt_regs.sv =====
`default_nettype none

module hpt_regs (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [hpt_pkg::ADDR_W-1:0] paddr,
    input  logic [hpt_pkg::DATA_W-1:0] pwdata,
    output logic [hpt_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output hpt_pkg::cfg_t              cfg
);
    import hpt_pkg::*;

    logic signed [16:0] target_reg;
    logic [27:0]        gain_p_reg;
    logic [27:0]        gain_i_reg;
    logic [27:0]        gain_d_reg;
    logic [15:0]        threshold_reg;
    reg_idx_t           reg_idx;
    logic               wr_en;

    assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg    <= TARGET_RST;
            gain_p_reg    <= GAIN_P_RST;
            gain_i_reg    <= GAIN_I_RST;
            gain_d_reg    <= GAIN_D_RST;
            threshold_reg <= THRESHOLD_RST;
        end else if (wr_en) begin
            case (reg_idx)
                REG_TARGET:    target_reg    <= $signed(pwdata[16:0]);
                REG_GAIN_P:    gain_p_reg    <= pwdata[27:0];
                REG_GAIN_I:    gain_i_reg    <= pwdata[27:0];
                REG_GAIN_D:    gain_d_reg    <= pwdata[27:0];
                REG_THRESHOLD: threshold_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_TARGET:    prdata = {{(DATA_W-17){target_reg[16]}}, target_reg};
            REG_GAIN_P:    prdata = {{(DATA_W-28){1'b0}}, gain_p_reg};
            REG_GAIN_I:    prdata = {{(DATA_W-28){1'b0}}, gain_i_reg};
            REG_GAIN_D:    prdata = {{(DATA_W-28){1'b0}}, gain_d_reg};
            REG_THRESHOLD: prdata = {{(DATA_W-16){1'b0}}, threshold_reg};
            default:       prdata = '0;
        endcase
    end

    always_comb begin
        cfg.target    = target_reg;
        cfg.gain_p    = gain_p_reg;
        cfg.gain_i    = gain_i_reg;
        cfg.gain_d    = gain_d_reg;
        cfg.threshold = threshold_reg;
    end

endmodule

`default_nettype wire

// ===== hdl/hpt_ctrl.sv =====
`default_nettype none

module hpt_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  hpt_pkg::status_t status,
    output hpt_pkg::cmd_t    cmd
);
    import hpt_pkg::*;

    typedef enum logic [11:0] {
        ST_IDLE  = 12'b000000000001,
        ST_WRAP  = 12'b000000000010,
        ST_UPD   = 12'b000000000100,
        ST_MD    = 12'b000000001000,
        ST_MIL   = 12'b000000010000,
        ST_MIH   = 12'b000000100000,
        ST_ISAT  = 12'b000001000000,
        ST_IADD  = 12'b000010000000,
        ST_CLAMP = 12'b000100000000,
        ST_MS    = 12'b001000000000,
        ST_MQ    = 12'b010000000000,
        ST_OUT   = 12'b100000000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_WRAP;
                end
            end
            ST_WRAP: begin
                cmd.wrap   = 1'b1;
                state_next = ST_UPD;
            end
            ST_UPD: begin
                cmd.update  = 1'b1;
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_P;
                state_next  = ST_MD;
            end
            ST_MD: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_D;
                cmd.acc_op  = ACC_LOAD_P;
                state_next  = ST_MIL;
            end
            ST_MIL: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_IL;
                cmd.acc_op  = ACC_ADD_D;
                state_next  = ST_MIH;
            end
            ST_MIH: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_IH;
                cmd.save_lo = 1'b1;
                state_next  = ST_ISAT;
            end
            ST_ISAT: begin
                cmd.isat   = 1'b1;
                state_next = ST_IADD;
            end
            ST_IADD: begin
                cmd.acc_op = ACC_ADD_I;
                state_next = ST_CLAMP;
            end
            ST_CLAMP: begin
                cmd.clamp  = 1'b1;
                state_next = ST_MS;
            end
            ST_MS: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_S;
                state_next  = ST_MQ;
            end
            ST_MQ: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_Q;
                state_next  = ST_OUT;
            end
            ST_OUT: begin
                if (!status.out_busy) begin
                    cmd.result = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_WRAP))
        else $error("accepted transfer did not start processing");
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !cmd.result && !cmd.mul_en)
        else $error("ready raised while datapath busy");
    a_out_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT && status.out_busy) |=> (state_reg == ST_OUT))
        else $error("result dropped while output held");
`endif

endmodule

`default_nettype wire

// ===== hdl/hpt_dp.sv =====
`default_nettype none

module hpt_dp (
    input  logic               aclk,
    input  logic               aresetn,
    input  hpt_pkg::cfg_t      cfg,
    input  hpt_pkg::cmd_t      cmd,
    output hpt_pkg::status_t   status,
    input  logic signed [16:0] s_measured_heading,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [11:0] m_speed_left,
    output logic signed [11:0] m_speed_right,
    output logic               m_stable_pulse
);
    import hpt_pkg::*;

    logic signed [16:0] meas_reg;
    logic signed [16:0] err_reg;
    logic signed [16:0] prev_err_reg;
    logic [39:0]        error_sum_reg;
    logic [5:0]         settle_count_reg;
    logic               pulse_reg;
    logic [16:0]        diff_mag_reg;
    logic               diff_neg_reg;
    logic [63:0]        prod_reg;
    logic [47:0]        ilo_reg;
    logic [52:0]        ilim_reg;
    logic [55:0]        acc_reg;
    logic [34:0]        dmag_reg;
    logic               drive_neg_reg;
    logic               m_valid_reg;
    logic signed [11:0] m_speed_left_reg;
    logic signed [11:0] m_speed_right_reg;
    logic               m_stable_pulse_reg;

    logic signed [17:0] raw_err;
    logic signed [17:0] wrap_err;
    logic signed [17:0] diff;
    logic [17:0]        diff_abs;
    logic [16:0]        err_mag;
    logic signed [40:0] sum_ext;
    logic [39:0]        sum_next;
    logic [39:0]        sum_mag;
    logic               settled;
    logic [5:0]         count_inc;
    logic [27:0]        mul_a;
    logic [35:0]        mul_b;
    logic [63:0]        mul_full;
    logic [55:0]        acc_term;
    logic               acc_neg;
    logic [55:0]        acc_base;
    logic [67:0]        ifull;
    logic [55:0]        acc_mag;
    logic [10:0]        smag;
    logic signed [11:0] speed;

    assign raw_err = $signed({cfg.target[16], cfg.target}) - $signed({meas_reg[16], meas_reg});

    always_comb begin
        if (raw_err > WRAP_HALF) begin
            wrap_err = raw_err - WRAP_FULL;
        end else if (raw_err < -WRAP_HALF) begin
            wrap_err = raw_err + WRAP_FULL;
        end else begin
            wrap_err = raw_err;
        end
    end

    assign err_mag   = err_reg[16] ? 17'(-err_reg) : 17'(err_reg);
    assign diff      = $signed({err_reg[16], err_reg}) - $signed({prev_err_reg[16], prev_err_reg});
    assign diff_abs  = diff[17] ? 18'(-diff) : 18'(diff);
    assign sum_ext   = $signed({error_sum_reg[39], error_sum_reg})
                     + $signed({{24{err_reg[16]}}, err_reg});
    assign sum_next  = (sum_ext[40] != sum_ext[39]) ? (sum_ext[40] ? SUM_MIN : SUM_MAX)
                                                    : sum_ext[39:0];
    assign sum_mag   = error_sum_reg[39] ? (40'd0 - error_sum_reg) : error_sum_reg;
    assign settled   = {1'b0, cfg.threshold} > diff_abs[16:0];
    assign count_inc = settle_count_reg + 6'd1;

    always_comb begin
        case (cmd.mul_sel)
            MUL_P: begin
                mul_a = cfg.gain_p;
                mul_b = {19'd0, err_mag};
            end
            MUL_D: begin
                mul_a = cfg.gain_d;
                mul_b = {19'd0, diff_mag_reg};
            end
            MUL_IL: begin
                mul_a = cfg.gain_i;
                mul_b = {16'd0, sum_mag[19:0]};
            end
            MUL_IH: begin
                mul_a = cfg.gain_i;
                mul_b = {16'd0, sum_mag[39:20]};
            end
            MUL_S: begin
                mul_a = SPEED_MUL;
                mul_b = {1'b0, dmag_reg};
            end
            MUL_Q: begin
                mul_a = RECIP_FIVE;
                mul_b = {23'd0, prod_reg[40:28]};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_full = mul_a * mul_b;

    always_comb begin
        case (cmd.acc_op)
            ACC_LOAD_P: begin
                acc_term = {1'b0, prod_reg[54:0]};
                acc_neg  = err_reg[16];
                acc_base = '0;
            end
            ACC_ADD_D: begin
                acc_term = {1'b0, prod_reg[54:0]};
                acc_neg  = diff_neg_reg;
                acc_base = acc_reg;
            end
            ACC_ADD_I: begin
                acc_term = {3'd0, ilim_reg};
                acc_neg  = error_sum_reg[39];
                acc_base = acc_reg;
            end
            default: begin
                acc_term = '0;
                acc_neg  = 1'b0;
                acc_base = acc_reg;
            end
        endcase
    end

    assign ifull   = {prod_reg[47:0], 20'd0} + {20'd0, ilo_reg};
    assign acc_mag = acc_reg[55] ? (56'd0 - acc_reg) : acc_reg;
    assign smag    = prod_reg[28:18];
    assign speed   = drive_neg_reg ? -$signed({1'b0, smag}) : $signed({1'b0, smag});

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            meas_reg <= s_measured_heading;
        end
        if (cmd.wrap) begin
            err_reg <= wrap_err[16:0];
        end
        if (cmd.update) begin
            diff_mag_reg <= diff_abs[16:0];
            diff_neg_reg <= diff[17];
        end
        if (cmd.mul_en) begin
            prod_reg <= mul_full;
        end
        if (cmd.acc_op != ACC_HOLD) begin
            acc_reg <= acc_base + (acc_neg ? (56'd0 - acc_term) : acc_term);
        end
        if (cmd.save_lo) begin
            ilo_reg <= prod_reg[47:0];
        end
        if (cmd.isat) begin
            ilim_reg <= (ifull > TERM_LIMIT) ? TERM_LIMIT[52:0] : ifull[52:0];
        end
        if (cmd.clamp) begin
            dmag_reg      <= (acc_mag > DRIVE_LIMIT) ? DRIVE_LIMIT[34:0] : acc_mag[34:0];
            drive_neg_reg <= acc_reg[55];
        end
        if (cmd.result) begin
            m_speed_right_reg  <= speed;
            m_speed_left_reg   <= -speed;
            m_stable_pulse_reg <= pulse_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_err_reg     <= '0;
            error_sum_reg    <= '0;
            settle_count_reg <= '0;
            pulse_reg        <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            if (cmd.update) begin
                prev_err_reg  <= err_reg;
                error_sum_reg <= sum_next;
                pulse_reg     <= 1'b0;
                if (settled) begin
                    if (count_inc >= SETTLE_STEPS) begin
                        settle_count_reg <= '0;
                        pulse_reg        <= 1'b1;
                    end else begin
                        settle_count_reg <= count_inc;
                    end
                end
            end
            if (cmd.result) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign status.out_busy = m_valid_reg & ~m_ready;
    assign m_valid         = m_valid_reg;
    assign m_speed_left    = m_speed_left_reg;
    assign m_speed_right   = m_speed_right_reg;
    assign m_stable_pulse  = m_stable_pulse_reg;

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        settle_count_reg < SETTLE_STEPS)
        else $error("settle count past limit");
    a_pulse_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        pulse_reg |-> (settle_count_reg == 6'd0))
        else $error("stable pulse without count clear");
    a_mirror: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_speed_left_reg == -m_speed_right_reg))
        else $error("wheel speeds not mirrored");
    a_speed_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_speed_right_reg <= 12'sd1560 && m_speed_right_reg >= -12'sd1560))
        else $error("speed beyond scale");
`endif

endmodule

`default_nettype wire
